### rtl/opr_pkg.sv
// shared constants, register indexes and weight table for the pressure relaxation block
`timescale 1ns / 1ps
`default_nettype none
package opr_pkg;

    localparam int DEF_MAX_DIM       = 64;
    localparam int DEF_NUM_LEVELS    = 4;
    localparam int DEF_PRESSURE_BITS = 32;

    localparam int WEIGHT_BITS = 20;
    localparam int COEFF_BITS  = 24;
    localparam int ACC_BITS    = 48;
    localparam int REG_BITS    = 7;
    localparam int APB_AW      = 4;

    localparam logic [COEFF_BITS-1:0] COEFF_MAX = {COEFF_BITS{1'b1}};

    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] REG_GRID_DEPTH  = 2'd2;

    localparam logic [REG_BITS-1:0] GRID_RESET = 7'd64;

    // Q.16 weight for a (cell level, neighbor level) pair
    function automatic logic [WEIGHT_BITS-1:0] weight(input logic [1:0] cl, input logic [1:0] nl);
        logic [WEIGHT_BITS-1:0] w;
        case ({cl, nl})
            4'b0000: w = 20'd65536;
            4'b0001: w = 20'd43691;
            4'b0010: w = 20'd26214;
            4'b0011: w = 20'd14564;
            4'b0100: w = 20'd43691;
            4'b0101: w = 20'd131072;
            4'b0110: w = 20'd87381;
            4'b0111: w = 20'd52429;
            4'b1000: w = 20'd26214;
            4'b1001: w = 20'd87381;
            4'b1010: w = 20'd262144;
            4'b1011: w = 20'd174763;
            4'b1100: w = 20'd14564;
            4'b1101: w = 20'd52429;
            4'b1110: w = 20'd174763;
            4'b1111: w = 20'd524288;
            default: w = 20'd65536;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

### rtl/opr_stream_if.sv
// valid/ready channel interfaces for neighbor items and relaxed pressure items
`timescale 1ns / 1ps
`default_nettype none
interface opr_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cell_level;
    logic [5:0]         cell_x;
    logic [5:0]         cell_y;
    logic [5:0]         cell_z;
    logic signed [31:0] cell_divergence;
    logic [1:0]         neighbor_level;
    logic signed [7:0]  nbr_x;
    logic signed [7:0]  nbr_y;
    logic signed [7:0]  nbr_z;
    logic               last_neighbor;

    modport source (output valid, cell_level, cell_x, cell_y, cell_z, cell_divergence,
                    neighbor_level, nbr_x, nbr_y, nbr_z, last_neighbor,
                    input ready);
    modport sink (input valid, cell_level, cell_x, cell_y, cell_z, cell_divergence,
                  neighbor_level, nbr_x, nbr_y, nbr_z, last_neighbor,
                  output ready);
endinterface

interface opr_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         out_level;
    logic [5:0]         out_x;
    logic [5:0]         out_y;
    logic [5:0]         out_z;
    logic signed [31:0] new_pressure;

    modport source (output valid, out_level, out_x, out_y, out_z, new_pressure, input ready);
    modport sink (input valid, out_level, out_x, out_y, out_z, new_pressure, output ready);
endinterface
`default_nettype wire

### rtl/octree_pressure_relax.sv
// top level: gauss-seidel pressure relaxation of one octree cell over a four-level store
// a neighbor item passes through two index multiply steps, a store read, multiply and accumulate
// the last neighbor of a cell adds setup steps (two cell index steps and a sign step), the bit-serial
// divider, a saturate step and a write/emit step that waits until the output register is free
// the result waits in an output register while the next item is accepted
// after reset the stores are cleared, one entry a cycle in all levels at once, until all
// MAX_DIM**3 entries of level 0 are done, with input not ready meanwhile; grid registers reset to 64
`timescale 1ns / 1ps
`default_nettype none
module octree_pressure_relax #(
    parameter int MAX_DIM       = opr_pkg::DEF_MAX_DIM,
    parameter int NUM_LEVELS    = opr_pkg::DEF_NUM_LEVELS,
    parameter int PRESSURE_BITS = opr_pkg::DEF_PRESSURE_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    opr_in_if.sink                           i_in,
    opr_out_if.source                        o_out,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [opr_pkg::APB_AW-1:0]  paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import opr_pkg::*;

    localparam int PB  = PRESSURE_BITS;
    localparam int DW  = $clog2(MAX_DIM + 1);
    localparam int TW  = $clog2(MAX_DIM * MAX_DIM);
    localparam int IW  = $clog2(MAX_DIM * MAX_DIM * MAX_DIM);
    localparam int CLR_DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int PW  = PB + WEIGHT_BITS + 1;
    localparam int SW  = ((PW > ACC_BITS) ? PW : ACC_BITS) + 1;
    localparam int MW1 = 8 + DW;
    localparam int MW2 = TW + DW + 1;

    localparam logic signed [SW-1:0] WS_MAX = {{(SW-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [SW-1:0] WS_MIN = {{(SW-ACC_BITS+1){1'b1}}, {(ACC_BITS-1){1'b0}}};
    localparam logic [63:0] PMAX = (64'd1 << (PB - 1)) - 64'd1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_IDX1 = 4'd1;
    localparam logic [3:0] S_IDX2 = 4'd2;
    localparam logic [3:0] S_RD   = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_ACC  = 4'd5;
    localparam logic [3:0] S_SIG  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_SAT  = 4'd8;
    localparam logic [3:0] S_EMIT = 4'd9;

    function automatic logic [DW-1:0] lvl_dim(input logic [REG_BITS-1:0] r, input logic [1:0] l);
        logic [9:0] d;
        d = (10'(r) > 10'(MAX_DIM)) ? 10'(MAX_DIM) : 10'(r);
        return DW'(d >> l);
    endfunction

    function automatic logic in_rng(input logic signed [7:0] c, input logic [DW-1:0] d);
        return !c[7] && (10'(c[6:0]) < 10'(d));
    endfunction

    // configuration
    logic [REG_BITS-1:0] r_gw, r_gh, r_gd;

    // sequencer and datapath registers
    logic [3:0]               r_state, n_state;
    logic                     r_clearing;
    logic [IW-1:0]            r_clr_cnt;
    logic                     r_phase_cell;
    logic [1:0]               r_lvl;
    logic signed [7:0]        r_x, r_y, r_z;
    logic [1:0]               r_clvl;
    logic [5:0]               r_cx, r_cy, r_cz;
    logic signed [31:0]       r_div;
    logic                     r_last;
    logic [WEIGHT_BITS-1:0]   r_wt;
    logic                     r_inside;
    logic [TW-1:0]            r_t;
    logic [IW-1:0]            r_idx;
    logic signed [PW-1:0]     r_prod;
    logic [COEFF_BITS-1:0]    r_coeff;
    logic signed [ACC_BITS-1:0] r_ws;
    logic                     r_neg;
    logic [63:0]              r_num;
    logic [COEFF_BITS:0]      r_rem;
    logic [63:0]              r_q;
    logic [5:0]               r_dcnt;
    logic signed [63:0]       r_res;
    logic                     r_out_valid;
    logic [1:0]               r_out_lvl;
    logic [5:0]               r_out_x, r_out_y, r_out_z;
    logic signed [31:0]       r_out_p;

    // combinational values
    logic [DW-1:0]           dim_w, dim_h, dim_d;
    logic [MW1-1:0]          prod_t;
    logic [MW2-1:0]          prod_i;
    logic [COEFF_BITS:0]     coeff_sum;
    logic [COEFF_BITS-1:0]   n_coeff;
    logic signed [SW-1:0]    acc_sum;
    logic signed [ACC_BITS-1:0] n_ws;
    logic signed [ACC_BITS:0]   sig49;
    logic signed [ACC_BITS-1:0] sigma;
    logic [ACC_BITS-1:0]     mag;
    logic [COEFF_BITS:0]     rem_sh;
    logic                    rem_ge;
    logic signed [63:0]      n_res;
    logic                    in_acc, out_free, wr_en, rd_en;
    logic [PB-1:0]           w_rd [NUM_LEVELS];
    logic [PB-1:0]           rd_sel;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign wr_en    = (r_state == S_EMIT) && out_free && r_inside;
    assign rd_en    = (r_state == S_RD) && r_inside;

    assign i_in.ready = (r_state == S_IDLE) && !r_clearing;

    assign o_out.valid        = r_out_valid;
    assign o_out.out_level    = r_out_lvl;
    assign o_out.out_x        = r_out_x;
    assign o_out.out_y        = r_out_y;
    assign o_out.out_z        = r_out_z;
    assign o_out.new_pressure = r_out_p;

    // apb register file
    assign pready = 1'b1;
    always_comb begin
        case (paddr[3:2])
            REG_GRID_WIDTH:  prdata = 32'(r_gw);
            REG_GRID_HEIGHT: prdata = 32'(r_gh);
            REG_GRID_DEPTH:  prdata = 32'(r_gd);
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw <= GRID_RESET;
            r_gh <= GRID_RESET;
            r_gd <= GRID_RESET;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
                REG_GRID_WIDTH:  r_gw <= pwdata[REG_BITS-1:0];
                REG_GRID_HEIGHT: r_gh <= pwdata[REG_BITS-1:0];
                REG_GRID_DEPTH:  r_gd <= pwdata[REG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // pressure stores, one per level
    for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_lvl
        localparam int DL  = (MAX_DIM >> g);
        localparam int DEP = (DL * DL * DL);
        localparam int AW  = ($clog2(DEP) < 1) ? 1 : $clog2(DEP);
        logic [PB-1:0] mem [DEP];
        logic [PB-1:0] r_rdq;
        logic          clr_we;
        assign clr_we  = r_clearing && ({1'b0, r_clr_cnt} < (IW+1)'(DEP));
        assign w_rd[g] = r_rdq;

        always_ff @(posedge i_clk) begin
            if (clr_we) begin
                mem[r_clr_cnt[AW-1:0]] <= '0;
            end else if (wr_en && (r_lvl == 2'(g))) begin
                mem[r_idx[AW-1:0]] <= r_res[PB-1:0];
            end
            if (rd_en && (r_lvl == 2'(g))) begin
                r_rdq <= mem[r_idx[AW-1:0]];
            end
        end
    end

    always_comb begin
        dim_w = lvl_dim(r_gw, r_lvl);
        dim_h = lvl_dim(r_gh, r_lvl);
        dim_d = lvl_dim(r_gd, r_lvl);
        prod_t = MW1'(r_z[6:0]) * MW1'(dim_h) + MW1'(r_y[6:0]);
        prod_i = MW2'(r_t) * MW2'(dim_w) + MW2'(r_x[6:0]);
        rd_sel = w_rd[r_lvl];

        coeff_sum = {1'b0, r_coeff} + (COEFF_BITS+1)'(weight(i_in.cell_level, i_in.neighbor_level));
        n_coeff   = coeff_sum[COEFF_BITS] ? COEFF_MAX : coeff_sum[COEFF_BITS-1:0];

        acc_sum = SW'(r_ws) + SW'(r_prod >>> 16);
        if (acc_sum > WS_MAX) begin
            n_ws = WS_MAX[ACC_BITS-1:0];
        end else if (acc_sum < WS_MIN) begin
            n_ws = WS_MIN[ACC_BITS-1:0];
        end else begin
            n_ws = acc_sum[ACC_BITS-1:0];
        end

        sig49 = {r_ws[ACC_BITS-1], r_ws} - (ACC_BITS+1)'(r_div);
        if (sig49[ACC_BITS] != sig49[ACC_BITS-1]) begin
            sigma = sig49[ACC_BITS] ? {1'b1, {(ACC_BITS-1){1'b0}}} : {1'b0, {(ACC_BITS-1){1'b1}}};
        end else begin
            sigma = sig49[ACC_BITS-1:0];
        end
        mag = sigma[ACC_BITS-1] ? (~sigma + 1'b1) : sigma;

        rem_sh = {r_rem[COEFF_BITS-1:0], r_num[63]};
        rem_ge = (rem_sh >= {1'b0, r_coeff});

        if (r_coeff == '0) begin
            n_res = '0;
        end else if (r_neg) begin
            n_res = (r_q > PMAX + 64'd1) ? -$signed(PMAX) - 64'sd1 : -$signed(r_q);
        end else begin
            n_res = (r_q > PMAX) ? $signed(PMAX) : $signed(r_q);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc) n_state = S_IDX1;
            S_IDX1: n_state = S_IDX2;
            S_IDX2: n_state = r_phase_cell ? S_SIG : S_RD;
            S_RD:   n_state = S_MUL;
            S_MUL:  n_state = S_ACC;
            S_ACC:  n_state = r_last ? S_IDX1 : S_IDLE;
            S_SIG:  n_state = S_DIV;
            S_DIV:  if (r_dcnt == 6'd63) n_state = S_SAT;
            S_SAT:  n_state = S_EMIT;
            S_EMIT: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_clearing   <= 1'b1;
            r_clr_cnt    <= '0;
            r_phase_cell <= 1'b0;
            r_coeff      <= '0;
            r_ws         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_clearing) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if ({1'b0, r_clr_cnt} == (IW+1)'(CLR_DEPTH - 1)) r_clearing <= 1'b0;
            end
            if ((r_state == S_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_phase_cell <= 1'b0;
                        r_lvl  <= i_in.neighbor_level;
                        r_x    <= i_in.nbr_x;
                        r_y    <= i_in.nbr_y;
                        r_z    <= i_in.nbr_z;
                        r_clvl <= i_in.cell_level;
                        r_cx   <= i_in.cell_x;
                        r_cy   <= i_in.cell_y;
                        r_cz   <= i_in.cell_z;
                        r_div  <= i_in.cell_divergence;
                        r_last <= i_in.last_neighbor;
                        r_wt   <= weight(i_in.cell_level, i_in.neighbor_level);
                        r_coeff <= n_coeff;
                    end
                end
                S_IDX1: begin
                    r_inside <= in_rng(r_x, dim_w) && in_rng(r_y, dim_h) && in_rng(r_z, dim_d);
                    r_t      <= prod_t[TW-1:0];
                end
                S_IDX2: r_idx <= prod_i[IW-1:0];
                S_MUL:  r_prod <= $signed(rd_sel) * $signed({1'b0, r_wt});
                S_ACC: begin
                    if (r_inside) r_ws <= n_ws;
                    // switch the index unit over to the cell itself
                    r_phase_cell <= 1'b1;
                    r_lvl <= r_clvl;
                    r_x   <= {2'b00, r_cx};
                    r_y   <= {2'b00, r_cy};
                    r_z   <= {2'b00, r_cz};
                end
                S_SIG: begin
                    r_neg  <= sigma[ACC_BITS-1];
                    r_num  <= {mag, 16'd0} + 64'(r_coeff >> 1);
                    r_rem  <= '0;
                    r_q    <= '0;
                    r_dcnt <= '0;
                end
                S_DIV: begin
                    // restoring division, one quotient bit per cycle
                    r_rem  <= rem_ge ? (rem_sh - {1'b0, r_coeff}) : rem_sh;
                    r_q    <= {r_q[62:0], rem_ge};
                    r_num  <= {r_num[62:0], 1'b0};
                    r_dcnt <= r_dcnt + 1'b1;
                end
                S_SAT: r_res <= n_res;
                S_EMIT: begin
                    if (out_free) begin
                        r_out_lvl   <= r_clvl;
                        r_out_x     <= r_cx;
                        r_out_y     <= r_cy;
                        r_out_z     <= r_cz;
                        r_out_p     <= r_res[31:0];
                        r_coeff     <= '0;
                        r_ws        <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/opr_checker.sv
// port-level checks on the pressure relaxation block, bound to its top level
`timescale 1ns / 1ps
`default_nettype none
module opr_props (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [31:0] i_out_pressure
);
    // a result waits until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("result dropped before taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> $stable(i_out_pressure))
        else $error("stalled result changed");

    // every item keeps the sequencer busy for at least the next cycle
    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("ready right after an item");

    // a new result never appears in the cycle after an item was taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_valid && i_in_ready))
        else $error("result without processing time");
endmodule

bind octree_pressure_relax opr_props u_opr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_pressure (o_out.new_pressure)
);
`default_nettype wire

### tb/opr_checker.sv
// checker: predicts relaxed pressure items from neighbor items and compares them
`timescale 1ns / 1ps
module opr_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    opr_in_if                          i_nb,
    opr_out_if                         i_pr,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic                       i_pready,
    input  logic [opr_pkg::APB_AW-1:0] i_paddr,
    input  logic [31:0]                i_pwdata,
    output int                         o_errors,
    output int                         o_pending
);
    import opr_pkg::*;

    typedef struct packed {
        logic [1:0]  lvl;
        logic [5:0]  x;
        logic [5:0]  y;
        logic [5:0]  z;
        logic [31:0] p;
    } relax_res_t;

    localparam int unsigned LINK_WEIGHT [4][4] = '{
        '{65536, 43691, 26214, 14564},
        '{43691, 131072, 87381, 52429},
        '{26214, 87381, 262144, 174763},
        '{14564, 52429, 174763, 524288}
    };
    localparam longint ACC_HI = 64'sd140737488355327;
    localparam longint ACC_LO = -64'sd140737488355328;

    int pres_l0 [262144];
    int pres_l1 [32768];
    int pres_l2 [4096];
    int pres_l3 [512];
    int unsigned coeff_acc;
    longint      wsum_acc;
    int          gw, gh, gd;
    relax_res_t  pressure_q [$];

    function automatic int lvl_size(int r, int lvl);
        return (r > 64 ? 64 : r) >> lvl;
    endfunction

    function automatic longint sat48(longint v);
        if (v > ACC_HI) return ACC_HI;
        if (v < ACC_LO) return ACC_LO;
        return v;
    endfunction

    // index into the level store, -1 when outside the grid
    function automatic int cell_index(int lvl, int x, int y, int z);
        int w, h, d;
        w = lvl_size(gw, lvl);
        h = lvl_size(gh, lvl);
        d = lvl_size(gd, lvl);
        if (x < 0 || y < 0 || z < 0 || x >= w || y >= h || z >= d) return -1;
        return (z * h + y) * w + x;
    endfunction

    function automatic int read_pres(int lvl, int idx);
        case (lvl)
            0: return pres_l0[idx];
            1: return pres_l1[idx];
            2: return pres_l2[idx];
            default: return pres_l3[idx];
        endcase
    endfunction

    always @(posedge i_clk) begin
        int unsigned w, c;
        int idx, cl, nl, res;
        longint sig;
        longint unsigned mag, q;
        relax_res_t exp_r, got_r;
        if (!i_rst_n) begin
            coeff_acc = 0;
            wsum_acc  = 0;
            gw = 64; gh = 64; gd = 64;
            pressure_q.delete();
            o_errors <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    REG_GRID_WIDTH:  gw = i_pwdata[6:0];
                    REG_GRID_HEIGHT: gh = i_pwdata[6:0];
                    REG_GRID_DEPTH:  gd = i_pwdata[6:0];
                    default: ;
                endcase
            end
            if (i_nb.valid && i_nb.ready) begin
                cl = i_nb.cell_level;
                nl = i_nb.neighbor_level;
                w = LINK_WEIGHT[cl][nl];
                c = coeff_acc + w;
                coeff_acc = c > 24'hFFFFFF ? 24'hFFFFFF : c;
                idx = cell_index(nl, i_nb.nbr_x, i_nb.nbr_y, i_nb.nbr_z);
                // arithmetic shift floors the product back to q16.16
                if (idx >= 0)
                    wsum_acc = sat48(wsum_acc +
                        ((longint'(read_pres(nl, idx)) * longint'(w)) >>> 16));
                if (i_nb.last_neighbor) begin
                    sig = sat48(wsum_acc - longint'(i_nb.cell_divergence));
                    res = 0;
                    if (coeff_acc != 0) begin
                        mag = sig < 0 ? -sig : sig;
                        q = ((mag << 16) + (coeff_acc >> 1)) / coeff_acc;
                        if (sig < 0) res = q > 64'd2147483648 ? 32'h80000000 : -q;
                        else res = q > 64'd2147483647 ? 32'h7FFFFFFF : q;
                    end
                    idx = cell_index(cl, i_nb.cell_x, i_nb.cell_y, i_nb.cell_z);
                    if (idx >= 0) begin
                        case (cl)
                            0: pres_l0[idx] = res;
                            1: pres_l1[idx] = res;
                            2: pres_l2[idx] = res;
                            default: pres_l3[idx] = res;
                        endcase
                    end
                    exp_r = '{i_nb.cell_level, i_nb.cell_x, i_nb.cell_y, i_nb.cell_z, res};
                    pressure_q.push_back(exp_r);
                    coeff_acc = 0;
                    wsum_acc  = 0;
                end
            end
            if (i_pr.valid && i_pr.ready) begin
                got_r = '{i_pr.out_level, i_pr.out_x, i_pr.out_y, i_pr.out_z,
                          i_pr.new_pressure};
                if (pressure_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected item: got %h", got_r);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = pressure_q.pop_front();
                    if (got_r !== exp_r) begin
                        if (o_errors < 10)
                            $display("mismatch: lvl %0d/%0d x %0d/%0d y %0d/%0d z %0d/%0d p %h/%h",
                                exp_r.lvl, got_r.lvl, exp_r.x, got_r.x, exp_r.y, got_r.y,
                                exp_r.z, got_r.z, exp_r.p, got_r.p);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= pressure_q.size();
    end
endmodule

### tb/tb.sv
// testbench top: clock, reset, neighbor stimulus, register writes and verdict
`timescale 1ns / 1ps
module tb;
    import opr_pkg::*;

    localparam int STALL_LIMIT = 1000000;
    localparam int TARGET_ITEMS = 1950;

    logic i_clk, i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [APB_AW-1:0] paddr;
    logic [31:0] pwdata, prdata;
    int errors, pending, idle_cycles, sent;
    bit vld_hi, rdy_hi, no_idle;
    int gw, gh, gd;

    opr_in_if  nb_if ();
    opr_out_if pr_if ();

    octree_pressure_relax u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(nb_if), .o_out(pr_if),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    opr_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_nb(nb_if), .i_pr(pr_if),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((nb_if.valid && nb_if.ready) || (pr_if.valid && pr_if.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // result side: random back-pressure per item
    initial begin
        int g;
        pr_if.ready <= 0;
        forever begin
            g = no_idle ? 0 : $urandom_range(0, 5);
            if (g > 0) begin
                if (rdy_hi) pr_if.ready <= 0;
                rdy_hi = 0;
                repeat (g) @(posedge i_clk);
            end
            pr_if.ready <= 1;
            rdy_hi = 1;
            @(posedge i_clk);
            while (!pr_if.valid) @(posedge i_clk);
        end
    end

    task automatic send_neighbor(input int cl, cx, cy, cz, div, nl, nx, ny, nz, last);
        int g;
        g = no_idle ? 0 : $urandom_range(0, 5);
        if (g > 0) begin
            if (vld_hi) nb_if.valid <= 0;
            vld_hi = 0;
            repeat (g) @(posedge i_clk);
        end
        nb_if.valid <= 1;
        nb_if.cell_level <= 2'(cl);
        nb_if.cell_x <= 6'(cx);
        nb_if.cell_y <= 6'(cy);
        nb_if.cell_z <= 6'(cz);
        nb_if.cell_divergence <= div;
        nb_if.neighbor_level <= 2'(nl);
        nb_if.nbr_x <= 8'(nx);
        nb_if.nbr_y <= 8'(ny);
        nb_if.nbr_z <= 8'(nz);
        nb_if.last_neighbor <= (last != 0);
        @(posedge i_clk);
        while (!nb_if.ready) @(posedge i_clk);
        vld_hi = 1;
        sent++;
    endtask

    // hold off until every pressure item is back and the block has gone quiet
    task automatic drain();
        if (vld_hi) nb_if.valid <= 0;
        vld_hi = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input int val);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge i_clk);
    endtask

    task automatic set_grid(input int w, h, d);
        reg_write(REG_GRID_WIDTH, w);
        reg_write(REG_GRID_HEIGHT, h);
        reg_write(REG_GRID_DEPTH, d);
        gw = w; gh = h; gd = d;
    endtask

    function automatic int axis_size(int r, int lvl);
        return (r > 64 ? 64 : r) >> lvl;
    endfunction

    function automatic int pick_coord(int s);
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? -1 : (s > 64 ? 64 : s);
        return s > 0 ? $urandom_range(0, s - 1) : -1;
    endfunction

    task automatic random_cell();
        int cl, el, nl;
        int cx, cy, cz;
        int div;
        int n;
        cl = $urandom_range(0, 3);
        if ($urandom_range(0, 9) == 0) begin
            cx = $urandom; cy = $urandom; cz = $urandom;
        end else begin
            cx = axis_size(gw, cl) > 0 ? $urandom_range(0, axis_size(gw, cl) - 1) : $urandom;
            cy = axis_size(gh, cl) > 0 ? $urandom_range(0, axis_size(gh, cl) - 1) : $urandom;
            cz = axis_size(gd, cl) > 0 ? $urandom_range(0, axis_size(gd, cl) - 1) : $urandom;
        end
        div = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2097152) - 1048576;
        // occasional long cell that can saturate the coefficient sum
        n = $urandom_range(0, 29) == 0 ? $urandom_range(34, 40) : $urandom_range(1, 8);
        for (int k = 0; k < n; k++) begin
            nl = $urandom_range(0, 3);
            el = $urandom_range(0, 6) == 0 ? $urandom_range(0, 3) : cl;
            if (k == n - 1)
                send_neighbor(cl, cx, cy, cz, div, nl, pick_coord(axis_size(gw, nl)),
                              pick_coord(axis_size(gh, nl)), pick_coord(axis_size(gd, nl)), 1);
            else
                send_neighbor(el, $urandom, $urandom, $urandom, $urandom, nl,
                              pick_coord(axis_size(gw, nl)), pick_coord(axis_size(gh, nl)),
                              pick_coord(axis_size(gd, nl)), 0);
        end
    endtask

    initial begin
        int presets [6][3];
        presets = '{'{8, 8, 8}, '{127, 0, 64}, '{0, 127, 8}, '{16, 40, 24},
                    '{56, 8, 64}, '{64, 64, 64}};
        i_rst_n <= 0;
        psel <= 0; penable <= 0; pwrite <= 0;
        paddr <= '0; pwdata <= '0;
        nb_if.valid <= 0; nb_if.cell_level <= 0; nb_if.cell_x <= 0; nb_if.cell_y <= 0;
        nb_if.cell_z <= 0; nb_if.cell_divergence <= 0; nb_if.neighbor_level <= 0;
        nb_if.nbr_x <= 0; nb_if.nbr_y <= 0; nb_if.nbr_z <= 0;
        nb_if.last_neighbor <= 0;
        gw = 64; gh = 64; gd = 64;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;

        // field extremes and boundary handling at the reset grid
        send_neighbor(0, 0, 0, 0, 0, 0, -1, -1, -1, 0);
        send_neighbor(0, 63, 63, 63, 32'hFFFFFFFF, 3, 63, 63, 63, 0);
        send_neighbor(0, 0, 0, 0, 0, 1, 31, 31, 31, 0);
        send_neighbor(0, 0, 0, 0, 32'h80000000, 2, 64, 0, 0, 1);
        // quotient saturates both ways
        send_neighbor(0, 1, 1, 1, 32'h80000000, 3, -1, -1, -1, 1);
        send_neighbor(0, 2, 2, 2, 32'h7FFFFFFF, 3, -1, -1, -1, 1);
        // every weight pair
        for (int c = 0; c < 4; c++)
            for (int n = 0; n < 4; n++)
                send_neighbor(c, 1, 2, 3, $urandom, n, 0, 0, n, int'(n == 3));
        drain();

        for (int ph = 0; sent < TARGET_ITEMS; ph++) begin
            if (ph < 6) set_grid(presets[ph][0], presets[ph][1], presets[ph][2]);
            else set_grid(8 * $urandom_range(1, 8), 8 * $urandom_range(1, 8),
                          8 * $urandom_range(1, 8));
            no_idle = (ph % 3 == 2);
            // cell outside a small grid still emits
            if (ph == 0) send_neighbor(0, 63, 9, 8, 0, 0, 2, 2, 2, 1);
            for (int k = 0; k < 240 && sent < TARGET_ITEMS; ) begin
                int before_cnt;
                before_cnt = sent;
                random_cell();
                k += sent - before_cnt;
            end
            drain();
        end

        if (errors == 0 && pending == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule

### files.f
rtl/opr_pkg.sv
rtl/opr_stream_if.sv
rtl/octree_pressure_relax.sv
rtl/opr_checker.sv
tb/opr_checker.sv
tb/tb.sv
